FILE: hw/rtl/multiclass_vigenere_decrypt_macros.svh
// assertion macros shared by the decryptor rtl
`ifndef MULTICLASS_VIGENERE_DECRYPT_MACROS_SVH
`define MULTICLASS_VIGENERE_DECRYPT_MACROS_SVH

// same-cycle implication, checked out of reset
`define MVD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MVD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mvd_pkg.sv
// shared types, constants and lookup functions for the vigenere decryptor
package mvd_pkg;

  localparam int KEY_BYTES_DEF = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int KEY_LEN_W     = 4;
  localparam int CHAR_W        = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int SYM_COUNT     = 29;
  localparam int IDX_W         = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_BYTES  = 1'b0,
    REG_KEY_LENGTH = 1'b1
  } cfg_reg_t;

  // class bounds
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7a;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 7'h5a;
  localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 7'h30;
  localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 7'h39;

  localparam logic [IDX_W-1:0] ALPHA_SIZE  = 5'd26;
  localparam logic [IDX_W-1:0] DIGIT_SIZE  = 5'd10;
  localparam logic [IDX_W-1:0] SYMBOL_SIZE = 5'd29;
  localparam logic [IDX_W-1:0] SYMBOL_LAST = 5'd28;

  // symbol class in index order, space last
  localparam logic [CHAR_W-1:0] SYM_TABLE [SYM_COUNT] = '{
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
    7'h5f, 7'h2b, 7'h2d, 7'h3d, 7'h5b, 7'h5d, 7'h7b, 7'h7d, 7'h7c, 7'h3b,
    7'h3a, 7'h22, 7'h2c, 7'h3c, 7'h2e, 7'h3e, 7'h2f, 7'h3f, 7'h20
  };

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } sym_hit_t;

  // 7-bit value modulo a class size of 10..29, by conditional subtraction
  function automatic logic [IDX_W-1:0] mod_small(input logic [CHAR_W-1:0] v,
                                                 input logic [IDX_W-1:0]  m);
    logic [7:0] acc;
    logic [7:0] step;
    acc = {1'b0, v};
    for (int i = 3; i >= 0; i--) begin
      step = {3'b000, m} << i;
      if (acc >= step) begin
        acc = acc - step;
      end
    end
    return acc[IDX_W-1:0];
  endfunction

  // index of a character in the symbol class
  function automatic sym_hit_t sym_lookup(input logic [CHAR_W-1:0] c);
    sym_hit_t hit;
    hit = '0;
    for (int i = 0; i < SYM_COUNT; i++) begin
      if (!hit.found && SYM_TABLE[i] == c) begin
        hit.found = 1'b1;
        hit.idx   = IDX_W'(i);
      end
    end
    return hit;
  endfunction

  // class index moved back by shift with wraparound, shift below size
  function automatic logic [IDX_W-1:0] back_shift(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] shift,
                                                  input logic [IDX_W-1:0] size);
    logic [IDX_W:0] sum;
    if (idx >= shift) begin
      sum = {1'b0, idx} - {1'b0, shift};
    end else begin
      sum = {1'b0, idx} + {1'b0, size} - {1'b0, shift};
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/mvd_key_ctrl.sv
// key storage, key length and key position tracking
module mvd_key_ctrl #(
  parameter int KEY_BYTES = mvd_pkg::KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mvd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             take,
  input  logic                             first,
  output logic [mvd_pkg::CHAR_W-1:0]       key_char
);
  import mvd_pkg::*;

  localparam int LenW = $clog2(KEY_BYTES + 1);
  localparam int PosW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  logic [CHAR_W-1:0] key_r   [KEY_BYTES];
  logic [CHAR_W-1:0] key_nxt [KEY_BYTES];
  logic [LenW-1:0]   len_r, len_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [PosW-1:0]   pos_use;
  logic [PosW:0]     pos_inc;
  logic [KEY_LEN_W-1:0] len_raw;
  logic [LenW-1:0]   len_eff;

  // position reduced below a new length
  function automatic logic [PosW-1:0] pos_wrap(input logic [PosW-1:0] p,
                                               input logic [LenW-1:0] n);
    logic [PosW:0] v;
    v = {1'b0, p};
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (v >= (PosW+1)'(n)) begin
        v = v - (PosW+1)'(n);
      end
    end
    return v[PosW-1:0];
  endfunction

  // key character for the incoming item
  assign pos_use  = first ? '0 : pos_r;
  assign key_char = key_r[pos_use];
  assign pos_inc  = {1'b0, pos_use} + (PosW+1)'(1);

  // clamp the written length into 1..KEY_BYTES
  assign len_raw = cfg_data[KEY_LEN_W-1:0];
  always_comb begin
    if (len_raw == '0) begin
      len_eff = LenW'(1);
    end else if (32'(len_raw) > KEY_BYTES) begin
      len_eff = LenW'(KEY_BYTES);
    end else begin
      len_eff = LenW'(len_raw);
    end
  end

  // next register values
  always_comb begin
    key_nxt = key_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_BYTES: begin
          for (int b = 0; b < KEY_BYTES; b++) begin
            key_nxt[b] = cfg_data[8*b +: CHAR_W];
          end
        end
        REG_KEY_LENGTH: begin
          len_nxt = len_eff;
          pos_nxt = pos_wrap(pos_r, len_eff);
        end
        default: begin
          len_nxt = len_r;
        end
      endcase
    end else if (take) begin
      pos_nxt = (pos_inc == (PosW+1)'(len_r)) ? '0 : pos_inc[PosW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < KEY_BYTES; b++) begin
        key_r[b] <= '0;
      end
      len_r <= LenW'(1);
      pos_r <= '0;
    end else begin
      key_r <= key_nxt;
      len_r <= len_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: hw/rtl/mvd_char_dec.sv
// per-character class decode and modular back shift
module mvd_char_dec (
  input  logic [mvd_pkg::CHAR_W-1:0] char_in,
  input  logic [mvd_pkg::CHAR_W-1:0] key_char,
  output logic [mvd_pkg::CHAR_W-1:0] char_out
);
  import mvd_pkg::*;

  logic             is_lower, is_upper, is_digit;
  logic [IDX_W-1:0] s_alpha, s_digit, s_sym;
  logic [IDX_W-1:0] lower_off, upper_off, digit_off;
  logic [IDX_W-1:0] sym_res;
  sym_hit_t         hit;

  // class detection
  assign is_lower = (char_in >= CH_LOWER_A) && (char_in <= CH_LOWER_Z);
  assign is_upper = (char_in >= CH_UPPER_A) && (char_in <= CH_UPPER_Z);
  assign is_digit = (char_in >= CH_DIGIT_0) && (char_in <= CH_DIGIT_9);

  // key shift per class size
  assign s_alpha = mod_small(key_char, ALPHA_SIZE);
  assign s_digit = mod_small(key_char, DIGIT_SIZE);
  assign s_sym   = mod_small(key_char, SYMBOL_SIZE);

  // offsets within each class
  assign lower_off = IDX_W'(char_in - CH_LOWER_A);
  assign upper_off = IDX_W'(char_in - CH_UPPER_A);
  assign digit_off = IDX_W'(char_in - CH_DIGIT_0);

  // symbol class, unknown characters act as index minus one
  assign hit     = sym_lookup(char_in);
  assign sym_res = hit.found ? back_shift(hit.idx, s_sym, SYMBOL_SIZE)
                             : SYMBOL_LAST - s_sym;

  // result character
  always_comb begin
    if (is_lower) begin
      char_out = CH_LOWER_A + CHAR_W'(back_shift(lower_off, s_alpha, ALPHA_SIZE));
    end else if (is_upper) begin
      char_out = CH_UPPER_A + CHAR_W'(back_shift(upper_off, s_alpha, ALPHA_SIZE));
    end else if (is_digit) begin
      char_out = CH_DIGIT_0 + CHAR_W'(back_shift(digit_off, s_digit, DIGIT_SIZE));
    end else begin
      char_out = SYM_TABLE[sym_res];
    end
  end

endmodule

FILE: hw/rtl/multiclass_vigenere_decrypt.sv
// top level of the repeating-key character decryptor
// items pass the input register, then the result register, one per cycle unless
// stalled; each accepted item advances the key position unless cfg_wr_en is high
// in_stall rises only when both stages hold items and the result is stalled
// reset (synchronous, rst_n low): pipeline empty, key bytes 0, key length 1, position 0
module multiclass_vigenere_decrypt #(
  parameter int KEY_BYTES = mvd_pkg::KEY_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mvd_pkg::CHAR_W-1:0]     in_char_in,
  input  logic                           in_first_of_message,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mvd_pkg::CHAR_W-1:0]     out_char_out,
  input  logic                           cfg_wr_en,
  input  logic [mvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mvd_pkg::*;
  `include "multiclass_vigenere_decrypt_macros.svh"

  logic              in_take, out_adv;
  logic [CHAR_W-1:0] key_char;
  logic              s1_v_r, s1_v_nxt;
  logic [CHAR_W-1:0] s1_char_r, s1_key_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, dec_char;

  // handshake
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  // key select and position tracking
  mvd_key_ctrl #(
    .KEY_BYTES (KEY_BYTES)
  ) u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (in_take),
    .first     (in_first_of_message),
    .key_char  (key_char)
  );

  // input register valid
  assign s1_v_nxt = in_take || (s1_v_r && !out_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // input register payload with its key character
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_in;
      s1_key_r  <= key_char;
    end
  end

  // character decode
  mvd_char_dec u_dec (
    .char_in  (s1_char_r),
    .key_char (s1_key_r),
    .char_out (dec_char)
  );

  // result register
  assign out_valid_nxt = out_adv ? s1_v_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      out_char_r <= dec_char;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;

  // pipeline checks
  `MVD_ASSERT_IMP(a_stall_only_full, in_stall, s1_v_r && out_valid_r && out_stall, "stall while not full")
  `MVD_ASSERT_NXT(a_take_fills_stage, in_take, s1_v_r, "accepted item lost at input register")
  `MVD_ASSERT_NXT(a_stage_drains, s1_v_r && out_adv, out_valid_r, "item lost between stages")

endmodule
